>>> rtl/bdmc_pkg.sv
// package: widths, register indexes and reset values of the button click detector
`timescale 1ns / 1ps

package bdmc_pkg;

  localparam int CountW = 8;
  localparam int CfgIdxW = 2;

  typedef logic [CountW-1:0] count_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam count_t COUNT_MAX = count_t'(255);
  localparam count_t FILTER_TICKS_RESET = count_t'(3);
  localparam count_t CLICK_GAP_TICKS_RESET = count_t'(30);

  localparam cfg_idx_t REG_FILTER_TICKS = cfg_idx_t'(0);
  localparam cfg_idx_t REG_CLICK_GAP_TICKS = cfg_idx_t'(1);

  // saturating increment
  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v < COUNT_MAX) ? v + count_t'(1) : v;
    return r;
  endfunction

endpackage

>>> rtl/button_debounce_multi_click.sv
// top level: button debounce with single and multi click detection
`timescale 1ns / 1ps

// channel   dir  handshake                  contents
// s_axis    in   s_axis_tvalid/tready       one tick: key_level, charging
// m_axis    out  m_axis_tvalid/tready       one result word per tick
// cfg       in   cfg_valid/cfg_ready        register index and 8 bit data
//
// every word passes an input register, then one level of counter logic that
// updates the debounce state and loads the result register; one word per cycle
// is sustained while the result is not stalled
// rst (synchronous) empties both registers and restores state and registers
// a stalled result holds the result register; the input register still fills,
// so one more word is taken before s_axis_tready drops
module button_debounce_multi_click
  import bdmc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [0] key_level, [1] charging, [7:2] zero
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // [0] debounced_pressed, [1] single_click,
                                      // [2] multi_click, [10:3] clicks_reported,
                                      // [18:11] hold_ticks, [26:19] pending_clicks,
                                      // [31:27] zero
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  cfg_idx_t     cfg_index,
  input  logic [7:0]   cfg_data
);

  // configuration registers
  count_t filter_ticks;
  count_t click_gap_ticks;

  // input register
  logic   in_valid;
  logic   in_key_level;
  logic   in_charging;

  // debounce state
  logic   accepted_level, accepted_level_next;
  logic   candidate_level, candidate_level_next;
  count_t stable_count, stable_count_next;
  count_t hold_count, hold_count_next;
  count_t gap_count, gap_count_next;
  count_t click_count, click_count_next;

  // per-tick event
  logic   single_next;
  logic   multi_next;
  count_t reported_next;

  // result register
  logic        out_valid;
  logic [31:0] out_data;

  logic   advance;
  logic   fire;
  logic   pressed;

  assign advance = !out_valid || m_axis_tready;
  assign fire = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

  // configuration writes; unused indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_ticks <= FILTER_TICKS_RESET;
      click_gap_ticks <= CLICK_GAP_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_TICKS:    filter_ticks <= cfg_data;
        REG_CLICK_GAP_TICKS: click_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_key_level <= s_axis_tdata[0];
      in_charging <= s_axis_tdata[1];
    end
  end

  // pin is active low
  assign pressed = !in_key_level;

  // state update for one tick
  always_comb begin
    accepted_level_next = accepted_level;
    candidate_level_next = candidate_level;
    stable_count_next = stable_count;
    hold_count_next = hold_count;
    gap_count_next = gap_count;
    click_count_next = click_count;
    single_next = 1'b0;
    multi_next = 1'b0;
    reported_next = '0;
    if (in_charging) begin
      // charging wipes everything
      accepted_level_next = 1'b0;
      candidate_level_next = 1'b0;
      stable_count_next = '0;
      hold_count_next = '0;
      gap_count_next = '0;
      click_count_next = '0;
    end else if (pressed != candidate_level) begin
      // level changed, restart the filter
      stable_count_next = '0;
      candidate_level_next = pressed;
    end else if (stable_count < filter_ticks) begin
      stable_count_next = stable_count + count_t'(1);
    end else begin
      if (accepted_level != pressed) begin
        if (!pressed) begin
          // release edge starts the gap
          gap_count_next = '0;
        end else begin
          // press edge counts a click
          hold_count_next = '0;
          click_count_next = sat_inc(click_count);
        end
      end else if (!pressed) begin
        if (click_count != '0) begin
          if (gap_count >= click_gap_ticks) begin
            reported_next = click_count;
            single_next = (click_count == count_t'(1));
            multi_next = (click_count != count_t'(1));
            click_count_next = '0;
          end else begin
            gap_count_next = sat_inc(gap_count);
          end
        end
      end else begin
        hold_count_next = sat_inc(hold_count);
      end
      accepted_level_next = pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_level <= 1'b0;
      candidate_level <= 1'b0;
      stable_count <= '0;
      hold_count <= '0;
      gap_count <= '0;
      click_count <= '0;
    end else if (fire) begin
      accepted_level <= accepted_level_next;
      candidate_level <= candidate_level_next;
      stable_count <= stable_count_next;
      hold_count <= hold_count_next;
      gap_count <= gap_count_next;
      click_count <= click_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {5'b0, click_count_next, hold_count_next, reported_next,
                   multi_next, single_next, accepted_level_next};
    end
  end

endmodule

>>> bench/tb_top.sv
// testbench for the button debounce and click detector: tick stream in, result words checked
`timescale 1ns / 1ps

module tb_top;
  import bdmc_pkg::*;

  // spare register indexes, writes to them must change nothing
  localparam cfg_idx_t REG_SPARE_A = cfg_idx_t'(2);
  localparam cfg_idx_t REG_SPARE_B = cfg_idx_t'(3);

  localparam int SETTLE_CYCLES = 4;       // a little over the pipeline latency
  localparam int DRAIN_LIMIT = 200_000;   // cycles a phase may take to drain
  localparam int MAX_WAIT = 13;           // longest idle drawn per word, either side

  // result word, pressed in bit 0 up to the zero pad at the top
  typedef struct packed {
    logic [4:0] pad;
    count_t     pending;
    count_t     hold;
    count_t     reported;
    logic       multi;
    logic       single;
    logic       pressed;
  } click_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] key_level, [1] charging, [7:2] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [0] pressed, [1] single, [2] multi, [10:3] reported,
                                    // [18:11] hold, [26:19] pending, [31:27] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  button_debounce_multi_click dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ticks waiting to be sent, {charging, key_level}
  logic [1:0]  tick_q[$];
  // predicted result words, oldest first
  click_word_t expected_q[$];

  int pushed_total = 0;   // ticks handed to the driver
  int ticks_taken = 0;    // ticks accepted by the block
  int err_count = 0;
  int send_gap = 0;
  int recv_wait = 0;
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;

  // predictor copy of the debounce state and the two settings
  logic   acc_pressed;
  logic   cand_pressed;
  count_t settle_cnt;
  count_t held_cnt;
  count_t gap_cnt;
  count_t pend_cnt;
  count_t filter_cfg;
  count_t gap_cfg;

  function automatic count_t bump(input count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

  // advance the predicted state by one tick and build the word it produces
  function automatic click_word_t predict_tick(input logic key_lvl, input logic chg);
    click_word_t w;
    logic press;
    w = '0;
    press = ~key_lvl;   // pin is active low
    if (chg) begin
      // charging wipes everything
      acc_pressed = 1'b0;
      cand_pressed = 1'b0;
      settle_cnt = '0;
      held_cnt = '0;
      gap_cnt = '0;
      pend_cnt = '0;
    end else if (press != cand_pressed) begin
      // new raw level, restart the filter
      settle_cnt = '0;
      cand_pressed = press;
    end else if (settle_cnt < filter_cfg) begin
      settle_cnt = settle_cnt + count_t'(1);
    end else begin
      if (acc_pressed != press) begin
        if (!press) begin
          gap_cnt = '0;
        end else begin
          held_cnt = '0;
          pend_cnt = bump(pend_cnt);
        end
      end else if (!press) begin
        if (pend_cnt != '0) begin
          if (gap_cnt >= gap_cfg) begin
            w.reported = pend_cnt;
            w.single = (pend_cnt == count_t'(1));
            w.multi = (pend_cnt != count_t'(1));
            pend_cnt = '0;
          end else begin
            gap_cnt = bump(gap_cnt);
          end
        end
      end else begin
        held_cnt = bump(held_cnt);
      end
      acc_pressed = press;
    end
    w.pressed = acc_pressed;
    w.hold = held_cnt;
    w.pending = pend_cnt;
    return w;
  endfunction

  // tick driver: takes ticks from tick_q, idles a drawn number of cycles between words,
  // and predicts each word on the edge that accepts it
  always @(posedge clk) begin : tick_driver
    logic [1:0] nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
      acc_pressed = 1'b0;
      cand_pressed = 1'b0;
      settle_cnt = '0;
      held_cnt = '0;
      gap_cnt = '0;
      pend_cnt = '0;
      filter_cfg = FILTER_TICKS_RESET;
      gap_cfg = CLICK_GAP_TICKS_RESET;
    end else begin
      // register writes only come while idle, so order against ticks does not matter
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILTER_TICKS: filter_cfg = cfg_data;
          REG_CLICK_GAP_TICKS: gap_cfg = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_tick(s_axis_tdata[0], s_axis_tdata[1]));
        ticks_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          nxt = tick_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'b0, nxt};
          send_gap <= send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // result monitor: stalls a drawn number of cycles after each word, checks every word
  always @(posedge clk) begin : result_monitor
    int stall;
    click_word_t seen;
    click_word_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, expected none got %h", $time, m_axis_tdata);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("debounced_pressed", 8'(want.pressed), 8'(seen.pressed));
        check_field("single_click", 8'(want.single), 8'(seen.single));
        check_field("multi_click", 8'(want.multi), 8'(seen.multi));
        check_field("clicks_reported", want.reported, seen.reported);
        check_field("hold_ticks", want.hold, seen.hold);
        check_field("pending_clicks", want.pending, seen.pending);
        check_field("pad bits", 8'(want.pad), 8'(seen.pad));
      end
      stall = recv_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      recv_wait <= stall;
      m_axis_tready <= (stall == 0);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      m_axis_tready <= (recv_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_ticks(input logic key, input logic chg, input int count);
    repeat (count) tick_q.push_back({chg, key});
    pushed_total += count;
  endtask

  // block until every tick is taken and every word checked, then let the pipe settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(posedge clk);
    while ((ticks_taken != pushed_total || expected_q.size() != 0) && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (guard == DRAIN_LIMIT) begin
      $display("%0t: words still outstanding, expected %0d got 0", $time, expected_q.size());
      err_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random press and release runs: mostly long enough to pass the filter, some glitches
  // shorter than the filter, now and then a short burst of charging with a random pin
  task automatic queue_runs(input int n_items, input int filt, input int gap);
    int left;
    int run;
    int kind;
    logic key;
    left = n_items;
    key = 1'b1;
    while (left > 0) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        run = $urandom_range(1, 3);
        repeat (run) push_ticks(1'($urandom_range(0, 1)), 1'b1, 1);
      end else begin
        key = ~key;
        if (kind < 4)
          run = $urandom_range(1, filt + 1);
        else if (key)
          run = filt + 2 + $urandom_range(0, gap + 4);   // release, may or may not end clicks
        else
          run = filt + 2 + $urandom_range(0, 5);
        if (run > left)
          run = left;
        push_ticks(key, 1'b0, run);
      end
      left -= run;
    end
  endtask

  initial begin : stimulus
    int filt;
    int gap;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings (filter 3, gap 30): glitch, press, charging, press and release
    push_ticks(1'b1, 1'b0, 2);
    push_ticks(1'b0, 1'b0, 2);   // glitch dies inside the filter
    push_ticks(1'b1, 1'b0, 1);
    push_ticks(1'b0, 1'b0, 6);   // accepted, hold starts counting
    push_ticks(1'b0, 1'b1, 1);   // charging while pressed
    push_ticks(1'b1, 1'b1, 1);
    push_ticks(1'b0, 1'b0, 6);
    push_ticks(1'b1, 1'b0, 6);   // release leaves one click pending
    wait_idle();

    // zero filter and zero gap, plus writes to the spare indexes
    write_reg(REG_FILTER_TICKS, 8'd0);
    write_reg(REG_CLICK_GAP_TICKS, 8'd0);
    write_reg(REG_SPARE_A, 8'hFF);
    write_reg(REG_SPARE_B, 8'h00);
    push_ticks(1'b1, 1'b0, 1);   // pending click reported at once
    push_ticks(1'b0, 1'b0, 2);
    push_ticks(1'b1, 1'b0, 3);   // single
    push_ticks(1'b0, 1'b0, 2);
    push_ticks(1'b1, 1'b0, 2);
    push_ticks(1'b0, 1'b0, 2);
    push_ticks(1'b1, 1'b0, 3);   // double click
    push_ticks(1'b0, 1'b0, 3);
    wait_idle();

    // longest gap: hold count runs into saturation, then a double click is reported
    // once the gap count reaches 255
    write_reg(REG_CLICK_GAP_TICKS, 8'd255);
    send_idle_on = 1'b0;
    push_ticks(1'b0, 1'b0, 262);
    push_ticks(1'b1, 1'b0, 2);
    push_ticks(1'b0, 1'b0, 2);
    push_ticks(1'b1, 1'b0, 262);
    wait_idle();

    // random phases, each under its own settings and idling mix
    for (int p = 0; p < 4; p++) begin
      filt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      write_reg(REG_FILTER_TICKS, 8'(filt));
      write_reg(REG_CLICK_GAP_TICKS, 8'(gap));
      send_idle_on = ($urandom_range(0, 2) != 0);
      recv_idle_on = ($urandom_range(0, 2) != 0);
      queue_runs(60, filt, gap);
      wait_idle();
    end

    if (err_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
